### rtl/scalar_kalman_level_filter_top_assert.svh
// Assertion macros shared by the level filter RTL.
// Included by the controller and datapath files; no other dependencies.
`ifndef SCALAR_KALMAN_LEVEL_FILTER_TOP_ASSERT_SVH
`define SCALAR_KALMAN_LEVEL_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SKLF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sklf: assertion failed");
`define SKLF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sklf: assertion failed");
`else
`define SKLF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SKLF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/sklf_pkg.sv
// Shared types and constants of the scalar Kalman level filter.
// No dependencies; used by the controller, datapath and top level.
package sklf_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] level_sample;
        logic       pump_on;
    } t_in;

    typedef struct packed {
        logic [6:0]  filtered_level;
        logic        ready_res;
        logic [23:0] estimate_out;
        logic [31:0] covariance_out;
    } t_res;

    typedef struct packed {
        logic capture;
        logic load;
        logic pred;
        logic den;
        logic div_step;
        logic mul_e;
        logic upd_e;
        logic upd_p;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic direct;
    } t_dp_sts;

    localparam logic [7:0] CFG_PROCESS_NOISE  = 8'd0;
    localparam logic [7:0] CFG_INITIAL_COV    = 8'd1;
    localparam logic [7:0] CFG_NOISE_PUMP_ON  = 8'd2;
    localparam logic [7:0] CFG_NOISE_PUMP_OFF = 8'd3;

    localparam logic [31:0] RST_PROCESS_NOISE  = 32'd65536;
    localparam logic [31:0] RST_INITIAL_COV    = 32'd65536;
    localparam logic [31:0] RST_NOISE_PUMP_ON  = 32'd2293760;
    localparam logic [31:0] RST_NOISE_PUMP_OFF = 32'd9830400;
    localparam logic [31:0] RST_COVARIANCE     = 32'd65536;

    localparam logic [6:0] LEVEL_MAX = 7'd100;

endpackage

### rtl/scalar_kalman_level_filter_top.sv
// Scalar Kalman level filter, top level: controller plus datapath.
// Depends on sklf_pkg, sklf_ctrl and sklf_dp.
//
// One item at a time. A restart or the first sample after reset or restart
// passes capture, load and emit into the output register; a filtered sample
// passes capture, prediction, the restoring divider for the gain, which
// resolves one quotient bit per cycle over FRAC_BITS + 1 steps, and the
// shared multiplier used once for the estimate and once for the covariance.
// A new input is taken once the previous result sits in the output register,
// even if it is not yet taken. Configuration writes are always ready and take
// effect at once.
module scalar_kalman_level_filter_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sklf_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sklf_pkg::t_res o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import sklf_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    sklf_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    sklf_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_out_data)
    );

endmodule

### rtl/sklf_ctrl.sv
// Sequencing controller of the level filter: state machine and divide counter.
// Depends on sklf_pkg and the assertion macro header.
`include "scalar_kalman_level_filter_top_assert.svh"

module sklf_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sklf_pkg::t_dp_sts i_sts,
    output sklf_pkg::t_dp_cmd o_cmd
);
    import sklf_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PRED = 8'b0000_0010,
        S_DEN  = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_MULE = 8'b0001_0000,
        S_UPDE = 8'b0010_0000,
        S_UPDP = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PRED;
                end
            end
            S_PRED: begin
                if (i_sts.direct) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    o_cmd.pred = 1'b1;
                    n_state    = S_DEN;
                end
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(FRAC_BITS)) begin
                    n_state = S_MULE;
                end
            end
            S_MULE: begin
                o_cmd.mul_e = 1'b1;
                n_state     = S_UPDE;
            end
            S_UPDE: begin
                o_cmd.upd_e = 1'b1;
                n_state     = S_UPDP;
            end
            S_UPDP: begin
                o_cmd.upd_p = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `SKLF_ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE)
    `SKLF_ASSERT_NXT(a_emit_sets_valid, i_clk, i_rst_n, r_state == S_EMIT && out_free, r_out_valid)
    `SKLF_ASSERT_IMP(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_cnt <= CW'(FRAC_BITS))

endmodule

### rtl/sklf_dp.sv
// Datapath of the level filter: config registers, filter state, restoring
// divider, shared multiplier and output register. Depends on sklf_pkg and macros.
`include "scalar_kalman_level_filter_top_assert.svh"

module sklf_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sklf_pkg::t_dp_cmd i_cmd,
    output sklf_pkg::t_dp_sts o_sts,
    input  sklf_pkg::t_in     i_in_data,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output sklf_pkg::t_res    o_res
);
    import sklf_pkg::*;

    localparam int EW = 8 + FRAC_BITS;
    localparam int BW = (EW > 32) ? EW : 32;
    localparam int QW = FRAC_BITS + 1;
    localparam int PW = QW + BW;

    localparam logic [QW-1:0] ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW:0]   HALF_P = {{(PW + 1 - FRAC_BITS){1'b0}}, 1'b1,
                                        {(FRAC_BITS - 1){1'b0}}};
    localparam logic [EW:0]   HALF_E = {{(EW + 1 - FRAC_BITS){1'b0}}, 1'b1,
                                        {(FRAC_BITS - 1){1'b0}}};

    logic [31:0]   r_q, r_p0, r_r_on, r_r_off;
    logic          r_cmd, r_pump;
    logic [EW-1:0] r_meas;
    logic [EW-1:0] r_est, n_est;
    logic [31:0]   r_cov;
    logic          r_primed;
    logic [31:0]   r_pp;
    logic [32:0]   r_den;
    logic          r_den_nz;
    logic [33:0]   r_rem;
    logic [QW-1:0] r_quot;
    logic          r_up;
    logic [EW-1:0] r_mag;
    logic [PW-1:0] r_prod;
    logic [6:0]    r_level;
    t_res          r_res;

    logic [32:0]   pp_sum;
    logic [31:0]   pp_sat;
    logic [32:0]   den_sum;
    logic [33:0]   trial;
    logic [33:0]   rem_sel;
    logic          div_bit;
    logic [QW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic [PW:0]   prod_rnd;
    logic [EW-1:0] corr;
    logic [EW:0]   est_rnd;
    logic [8:0]    lvl_full;
    logic [6:0]    lvl_clamp;
    logic [7:0]    sample;
    logic [6:0]    sample_clamp;
    logic [31:0]   est32;

    assign pp_sum  = {1'b0, r_cov} + {1'b0, r_q};
    assign pp_sat  = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
    assign den_sum = {1'b0, r_pp} + {1'b0, (r_pump ? r_r_on : r_r_off)};

    assign trial   = r_rem - {1'b0, r_den};
    assign div_bit = (r_rem >= {1'b0, r_den}) && r_den_nz;
    assign rem_sel = div_bit ? trial : r_rem;

    assign mul_a = i_cmd.mul_e ? r_quot : (ONE - r_quot);
    assign mul_b = i_cmd.mul_e ? BW'(r_mag) : BW'(r_pp);
    assign mul_p = {{BW{1'b0}}, mul_a} * {{QW{1'b0}}, mul_b};

    assign prod_rnd = {1'b0, r_prod} + HALF_P;
    assign corr     = prod_rnd[FRAC_BITS +: EW];

    always_comb begin
        if (r_up) begin
            n_est = r_est + corr;
        end else if (corr > r_est) begin
            n_est = '0;
        end else begin
            n_est = r_est - corr;
        end
    end

    assign est_rnd   = {1'b0, r_est} + HALF_E;
    assign lvl_full  = est_rnd[FRAC_BITS +: 9];
    assign lvl_clamp = (lvl_full > 9'(LEVEL_MAX)) ? LEVEL_MAX : lvl_full[6:0];

    assign sample       = r_meas[FRAC_BITS +: 8];
    assign sample_clamp = (sample > 8'(LEVEL_MAX)) ? LEVEL_MAX : sample[6:0];

    assign est32 = 32'(r_est);

    assign o_sts.direct = r_cmd || !r_primed;
    assign o_res        = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q     <= RST_PROCESS_NOISE;
            r_p0    <= RST_INITIAL_COV;
            r_r_on  <= RST_NOISE_PUMP_ON;
            r_r_off <= RST_NOISE_PUMP_OFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROCESS_NOISE:  r_q     <= i_cfg_data;
                CFG_INITIAL_COV:    r_p0    <= i_cfg_data;
                CFG_NOISE_PUMP_ON:  r_r_on  <= i_cfg_data;
                CFG_NOISE_PUMP_OFF: r_r_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est    <= '0;
            r_cov    <= RST_COVARIANCE;
            r_primed <= 1'b0;
        end else if (i_cmd.load) begin
            r_est    <= r_cmd ? '0 : r_meas;
            r_cov    <= r_p0;
            r_primed <= !r_cmd;
        end else if (i_cmd.upd_e) begin
            r_est <= n_est;
        end else if (i_cmd.upd_p) begin
            r_cov <= prod_rnd[FRAC_BITS +: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_in_data.cmd;
            r_pump <= i_in_data.pump_on;
            r_meas <= {i_in_data.level_sample, {FRAC_BITS{1'b0}}};
        end
        if (i_cmd.load) begin
            r_level <= r_cmd ? '0 : sample_clamp;
        end
        if (i_cmd.pred) begin
            r_pp  <= pp_sat;
            r_up  <= (r_meas >= r_est);
            r_mag <= (r_meas >= r_est) ? (r_meas - r_est) : (r_est - r_meas);
        end
        if (i_cmd.den) begin
            r_den    <= den_sum;
            r_den_nz <= (den_sum != '0);
            r_rem    <= {2'b00, r_pp};
            r_quot   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= {rem_sel[32:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], div_bit};
        end
        if (i_cmd.mul_e || i_cmd.upd_e) begin
            r_prod <= mul_p;
        end
        if (i_cmd.upd_p) begin
            r_level <= lvl_clamp;
        end
        if (i_cmd.emit) begin
            r_res.filtered_level <= r_level;
            r_res.ready_res      <= r_primed;
            r_res.estimate_out   <= est32[23:0];
            r_res.covariance_out <= r_cov;
        end
    end

    `SKLF_ASSERT_IMP(a_gain_le_one, i_clk, i_rst_n, i_cmd.mul_e, r_quot <= ONE)
    `SKLF_ASSERT_NXT(a_cov_shrinks, i_clk, i_rst_n, i_cmd.upd_p, r_cov <= r_pp)
    `SKLF_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, i_cmd.div_step, r_rem < {r_den, 1'b0} || !r_den_nz)

endmodule
